// ----- rtl/core/s2l_pkg.sv -----
// ----------------------------------------------------------------------------
// s2l_pkg
// Shared types, constants and tables for the solar to lunar date unit.
// ----------------------------------------------------------------------------
package s2l_pkg;

   localparam int FIRST_YEAR_DEF = 2020;
   localparam int YEAR_COUNT_DEF = 11;
   localparam int TABLE_LEN      = 11;

   localparam int IDX_W  = $clog2(TABLE_LEN);
   localparam int DN_W   = 22;   // day number
   localparam int DIFF_W = 10;   // days into the lunar year
   localparam int PC_W   = 4;

   // day number arithmetic
   localparam int MUL_DIV100   = 5243;  // floor(y/100) = (y*5243) >> 19 for y < 4096
   localparam int DIV100_SHIFT = 19;
   localparam int JD_YEAR_OFS  = 4716;
   localparam int DAYS_4Y      = 1461;
   localparam int JD_BIAS      = 1523;  // 1525 minus the constant 2 of the century term

   // microcode addresses
   localparam logic [PC_W-1:0] PC_START = 4'd0;
   localparam logic [PC_W-1:0] PC_NY    = 4'd4;
   localparam logic [PC_W-1:0] PC_WALK  = 4'd8;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_YEAR  = 2'd1,
      ST_NO_PREV  = 2'd2,
      ST_PAST_END = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      OP_FIND,
      OP_MUL_A,
      OP_MUL_B,
      OP_SUM,
      OP_CMP,
      OP_WALK
   } op_type;

   typedef enum logic {
      SRC_NOW,
      SRC_NY
   } src_type;

   typedef struct packed {
      op_type            op;
      src_type           src;
      logic [PC_W-1:0]   target;
   } uword_type;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   typedef struct packed {
      logic       load;
      logic       run;
      uword_type  uw;
   } dp_ctl_type;

   typedef struct packed {
      logic finish;
      logic jump;
   } dp_flags_type;

   typedef struct packed {
      status_type         status;
      logic [4:0]         lunar_day;
      logic [3:0]         lunar_month;
      logic [11:0]        lunar_year;
      logic               leap_flag;
      logic [4:0]         month_length;
      logic [DN_W-1:0]    month_start_day_number;
   } result_type;

   typedef struct packed {
      logic [4:0]   ny_day;
      logic [3:0]   ny_month;
      logic [3:0]   leap_month;
      logic [12:0]  map;
   } year_entry_type;

   function automatic year_entry_type year_entry(input logic [IDX_W-1:0] idx);
      year_entry_type e;
      e = '0;
      unique case (idx)
         4'd0:    e = '{5'd25, 4'd1, 4'd4, 13'h1A95};
         4'd1:    e = '{5'd12, 4'd2, 4'd0, 13'h0D4A};
         4'd2:    e = '{5'd1,  4'd2, 4'd0, 13'h0DA5};
         4'd3:    e = '{5'd22, 4'd1, 4'd2, 13'h15AA};
         4'd4:    e = '{5'd10, 4'd2, 4'd0, 13'h056A};
         4'd5:    e = '{5'd29, 4'd1, 4'd0, 13'h0AAD};
         4'd6:    e = '{5'd17, 4'd2, 4'd6, 13'h1556};
         4'd7:    e = '{5'd6,  4'd2, 4'd0, 13'h0A5B};
         4'd8:    e = '{5'd26, 4'd1, 4'd5, 13'h152B};
         4'd9:    e = '{5'd13, 4'd2, 4'd0, 13'h0A2B};
         4'd10:   e = '{5'd3,  4'd2, 4'd0, 13'h0953};
         default: e = '0;
      endcase
      return e;
   endfunction

   // floor((mm+1)*30.6001)
   function automatic logic [8:0] month_offset(input logic [3:0] mm);
      logic [8:0] v;
      v = '0;
      unique case (mm)
         4'd0:  v = 9'd30;
         4'd1:  v = 9'd61;
         4'd2:  v = 9'd91;
         4'd3:  v = 9'd122;
         4'd4:  v = 9'd153;
         4'd5:  v = 9'd183;
         4'd6:  v = 9'd214;
         4'd7:  v = 9'd244;
         4'd8:  v = 9'd275;
         4'd9:  v = 9'd306;
         4'd10: v = 9'd336;
         4'd11: v = 9'd367;
         4'd12: v = 9'd397;
         4'd13: v = 9'd428;
         4'd14: v = 9'd459;
         4'd15: v = 9'd489;
      endcase
      return v;
   endfunction

endpackage

// ----- rtl/core/s2l_urom.sv -----
// ----------------------------------------------------------------------------
// s2l_urom
// Microcode store: one control word per sequencer step.
// ----------------------------------------------------------------------------
module s2l_urom
   import s2l_pkg::*;
(
   input  logic [PC_W-1:0]  addr,
   output uword_type        uw
);

   always_comb begin
      unique case (addr)
         4'd0:    uw = '{op: OP_FIND,  src: SRC_NOW, target: PC_START};
         4'd1:    uw = '{op: OP_MUL_A, src: SRC_NOW, target: PC_START};
         4'd2:    uw = '{op: OP_MUL_B, src: SRC_NOW, target: PC_START};
         4'd3:    uw = '{op: OP_SUM,   src: SRC_NOW, target: PC_START};
         4'd4:    uw = '{op: OP_MUL_A, src: SRC_NY,  target: PC_START};
         4'd5:    uw = '{op: OP_MUL_B, src: SRC_NY,  target: PC_START};
         4'd6:    uw = '{op: OP_SUM,   src: SRC_NY,  target: PC_START};
         // retry with the previous year's new year date
         4'd7:    uw = '{op: OP_CMP,   src: SRC_NY,  target: PC_NY};
         // walk one month per step until the date falls inside
         4'd8:    uw = '{op: OP_WALK,  src: SRC_NY,  target: PC_WALK};
         default: uw = '{op: OP_FIND,  src: SRC_NOW, target: PC_START};
      endcase
   end

endmodule

// ----- rtl/core/s2l_seq.sv -----
// ----------------------------------------------------------------------------
// s2l_seq
// Step counter and control for the microcode program.
// ----------------------------------------------------------------------------
module s2l_seq
   import s2l_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          out_free,
   input  dp_flags_type  flags,
   output dp_ctl_type    ctl,
   output logic          req_stall,
   output logic          out_load
);

   seq_state_type    state_ff, state_in;
   logic [PC_W-1:0]  pc_ff, pc_in;
   uword_type        uw;

   s2l_urom u_urom (
      .addr (pc_ff),
      .uw   (uw)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         pc_ff    <= PC_START;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      pc_in     = pc_ff;
      ctl.load  = 1'b0;
      ctl.run   = 1'b0;
      ctl.uw    = uw;
      out_load  = 1'b0;
      req_stall = 1'b1;
      unique case (state_ff)
         SEQ_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctl.load = 1'b1;
               pc_in    = PC_START;
               state_in = SEQ_RUN;
            end
         end
         SEQ_RUN: begin
            ctl.run = 1'b1;
            if (flags.finish) begin
               // hold on the final step until the result register frees up
               if (out_free) begin
                  out_load = 1'b1;
                  state_in = SEQ_IDLE;
               end
            end else if (flags.jump) begin
               pc_in = uw.target;
            end else begin
               pc_in = pc_ff + 4'd1;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

endmodule

// ----- rtl/core/s2l_dpath.sv -----
// ----------------------------------------------------------------------------
// s2l_dpath
// Datapath: year lookup, day number unit with a shared multiplier, month walk.
// ----------------------------------------------------------------------------
module s2l_dpath
   import s2l_pkg::*;
#(
   parameter int FIRST_YEAR = FIRST_YEAR_DEF,
   parameter int YEAR_COUNT = YEAR_COUNT_DEF
)
(
   input  logic          clock,
   input  dp_ctl_type    ctl,
   input  logic [4:0]    req_solar_day,
   input  logic [3:0]    req_solar_month,
   input  logic [11:0]   req_solar_year,
   output dp_flags_type  flags,
   output result_type    result
);

   localparam int YEAR_LIMIT = (YEAR_COUNT < TABLE_LEN) ? YEAR_COUNT : TABLE_LEN;

   logic [4:0]         sd_ff;
   logic [3:0]         sm_ff;
   logic [11:0]        sy_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic               prev_ff;
   logic [5:0]         a_ff;
   logic [DN_W-1:0]    p_ff;
   logic [DN_W-1:0]    now_ff;
   logic [DN_W-1:0]    start_ff;
   logic [DIFF_W-1:0]  diff_ff;
   logic [DN_W-1:0]    acc_ff;
   logic [3:0]         month_ff;
   logic               leap_ff;
   logic [3:0]         i_ff;

   year_entry_type     e;
   logic [11:0]        ny_year;
   logic [12:0]        k;
   logic               hit;
   logic [4:0]         d_sel;
   logic [3:0]         m_sel;
   logic [11:0]        y_sel;
   logic               early;
   logic [3:0]         mm;
   logic [11:0]        yy;
   logic [13:0]        mul_a;
   logic [12:0]        mul_b;
   logic [26:0]        prod;
   logic [22:0]        dn_sum;
   logic               now_lt;
   logic [DN_W-1:0]    diff_full;
   logic [3:0]         months_m1;
   logic [3:0]         bitpos;
   logic [4:0]         len;
   logic               fits;

   assign e       = year_entry(idx_ff);
   assign ny_year = 12'(FIRST_YEAR) + {{(12-IDX_W){1'b0}}, idx_ff};

   assign k   = {1'b0, sy_ff} - 13'(FIRST_YEAR);
   assign hit = (sy_ff >= 12'(FIRST_YEAR)) && (k < 13'(YEAR_LIMIT));

   // day number operands; January and February count as months 13 and 14
   assign d_sel = (ctl.uw.src == SRC_NOW) ? sd_ff : e.ny_day;
   assign m_sel = (ctl.uw.src == SRC_NOW) ? sm_ff : e.ny_month;
   assign y_sel = (ctl.uw.src == SRC_NOW) ? sy_ff : ny_year;
   assign early = (m_sel <= 4'd2);
   assign mm    = early ? (m_sel + 4'd12) : m_sel;
   assign yy    = early ? (y_sel - 12'd1) : y_sel;

   assign mul_a = (ctl.uw.op == OP_MUL_A) ? {2'b00, yy} : ({2'b00, yy} + 14'(JD_YEAR_OFS));
   assign mul_b = (ctl.uw.op == OP_MUL_A) ? 13'(MUL_DIV100) : 13'(DAYS_4Y);
   assign prod  = 27'(mul_a) * 27'(mul_b);

   assign dn_sum = {1'b0, p_ff} + 23'(d_sel) + 23'(month_offset(mm))
                 + 23'(a_ff[5:2]) - 23'(a_ff) - 23'(JD_BIAS);

   assign now_lt    = (now_ff < start_ff);
   assign diff_full = now_ff - start_ff;

   assign months_m1 = (e.leap_month != 4'd0) ? 4'd12 : 4'd11;
   assign bitpos    = months_m1 - i_ff;
   assign len       = e.map[bitpos] ? 5'd30 : 5'd29;
   assign fits      = (diff_ff < DIFF_W'(len));

   always_comb begin
      flags.finish = 1'b0;
      flags.jump   = 1'b0;
      result       = '0;
      result.status = ST_OK;
      unique case (ctl.uw.op)
         OP_FIND: begin
            if (!hit) begin
               flags.finish  = 1'b1;
               result.status = ST_NO_YEAR;
            end
         end
         OP_CMP: begin
            if (now_lt) begin
               if (prev_ff) begin
                  flags.finish  = 1'b1;
                  result.status = ST_PAST_END;
               end else if (idx_ff == '0) begin
                  flags.finish  = 1'b1;
                  result.status = ST_NO_PREV;
               end else begin
                  flags.jump = 1'b1;
               end
            end
         end
         OP_WALK: begin
            if (fits) begin
               flags.finish                  = 1'b1;
               result.status                 = ST_OK;
               result.lunar_day              = 5'(diff_ff) + 5'd1;
               result.lunar_month            = month_ff;
               result.lunar_year             = ny_year;
               result.leap_flag              = leap_ff;
               result.month_length           = len;
               result.month_start_day_number = acc_ff;
            end else if (i_ff == months_m1) begin
               flags.finish  = 1'b1;
               result.status = ST_PAST_END;
            end else begin
               flags.jump = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         sd_ff <= req_solar_day;
         sm_ff <= req_solar_month;
         sy_ff <= req_solar_year;
      end
      if (ctl.run && !flags.finish) begin
         unique case (ctl.uw.op)
            OP_FIND: begin
               idx_ff  <= k[IDX_W-1:0];
               prev_ff <= 1'b0;
            end
            OP_MUL_A: a_ff <= prod[DIV100_SHIFT+5:DIV100_SHIFT];
            OP_MUL_B: p_ff <= prod[DN_W+1:2];
            OP_SUM: begin
               if (ctl.uw.src == SRC_NOW) begin
                  now_ff <= dn_sum[DN_W-1:0];
               end else begin
                  start_ff <= dn_sum[DN_W-1:0];
               end
            end
            OP_CMP: begin
               if (now_lt) begin
                  idx_ff  <= idx_ff - IDX_W'(1);
                  prev_ff <= 1'b1;
               end else begin
                  diff_ff  <= diff_full[DIFF_W-1:0];
                  acc_ff   <= start_ff;
                  month_ff <= 4'd1;
                  leap_ff  <= 1'b0;
                  i_ff     <= 4'd0;
               end
            end
            OP_WALK: begin
               diff_ff <= diff_ff - DIFF_W'(len);
               acc_ff  <= acc_ff + DN_W'(len);
               i_ff    <= i_ff + 4'd1;
               // the month after the leap month repeats its number
               if (e.leap_month != 4'd0 && month_ff == e.leap_month && !leap_ff) begin
                  leap_ff <= 1'b1;
               end else begin
                  month_ff <= month_ff + 4'd1;
                  leap_ff  <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

endmodule

// ----- rtl/core/solar_to_lunar_date_unit.sv -----
// ----------------------------------------------------------------------------
// solar_to_lunar_date_unit
// Gregorian to lunisolar date conversion from a built-in year table.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall) carries a Gregorian day, month
//   and year. Each request yields exactly one response on the rsp channel
//   (rsp_valid / rsp_stall): status, lunar day, month, year, leap flag,
//   month length and the day number of the month's first day. Fields other
//   than status are zero when status is not OK.
//   The microcode sequencer runs one step per cycle, but holds on its last
//   step while the response register is full. A year not in the table ends
//   after 1 step; otherwise 8 steps compute and compare the day numbers,
//   4 more when the date precedes the lunar new year, then one step per
//   lunar month walked (up to 13). The last step loads the response register.
//   Throughput: one request at a time; req_stall is high while the sequencer
//   is busy and drops while it is idle after the last step. A finished
//   response waits in its register while a new request is taken; a second
//   finished response holds the sequencer on its last step until rsp_stall
//   drops.
//   Reset (synchronous, active high) empties the response register and
//   returns the sequencer to idle.
// ----------------------------------------------------------------------------
module solar_to_lunar_date_unit
   import s2l_pkg::*;
#(
   parameter int FIRST_YEAR = FIRST_YEAR_DEF,
   parameter int YEAR_COUNT = YEAR_COUNT_DEF
)
(
   input  logic           clock,
   input  logic           reset,

   input  logic           req_valid,
   output logic           req_stall,
   input  logic [4:0]     req_solar_day,
   input  logic [3:0]     req_solar_month,
   input  logic [11:0]    req_solar_year,

   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic [1:0]     rsp_status,
   output logic [4:0]     rsp_lunar_day,
   output logic [3:0]     rsp_lunar_month,
   output logic [11:0]    rsp_lunar_year,
   output logic           rsp_leap_flag,
   output logic [4:0]     rsp_month_length,
   output logic [21:0]    rsp_month_start_day_number
);

   dp_ctl_type    ctl;
   dp_flags_type  flags;
   result_type    result;
   result_type    rsp_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;
   logic          out_load;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   s2l_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .flags     (flags),
      .ctl       (ctl),
      .req_stall (req_stall),
      .out_load  (out_load)
   );

   s2l_dpath #(
      .FIRST_YEAR (FIRST_YEAR),
      .YEAR_COUNT (YEAR_COUNT)
   ) u_dpath (
      .clock           (clock),
      .ctl             (ctl),
      .req_solar_day   (req_solar_day),
      .req_solar_month (req_solar_month),
      .req_solar_year  (req_solar_year),
      .flags           (flags),
      .result          (result)
   );

   // response register: refilled on the transfer cycle or when empty
   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid                  = rsp_valid_ff;
   assign rsp_status                 = rsp_ff.status;
   assign rsp_lunar_day              = rsp_ff.lunar_day;
   assign rsp_lunar_month            = rsp_ff.lunar_month;
   assign rsp_lunar_year             = rsp_ff.lunar_year;
   assign rsp_leap_flag              = rsp_ff.leap_flag;
   assign rsp_month_length           = rsp_ff.month_length;
   assign rsp_month_start_day_number = rsp_ff.month_start_day_number;

endmodule
